/* sv/adsr_envelope_generator_core_assert.svh */
// Assertion macros for the envelope generator core.
// Relies on clk and arst_n being visible where the macros are used.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adsr core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adsr core: next-cycle check failed");

`endif

/* sv/adsr_pkg.sv */
// Shared constants for the envelope generator core: phase codes and
// configuration register indexes. No dependencies.
`default_nettype none

package adsr_pkg;

	localparam int PHASE_W = 3;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 3'd4;

endpackage

`default_nettype wire

/* sv/adsr_cfg.sv */
// Configuration register file of the envelope generator core.
// Depends on adsr_pkg for the register indexes.
`default_nettype none

module adsr_cfg
	import adsr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [FRAC_BITS:0]     cfg_wdata,
	output logic      [FRAC_BITS:0]     attack_coeff,
	output logic      [FRAC_BITS:0]     decay_coeff,
	output logic      [FRAC_BITS:0]     release_coeff,
	output logic      [FRAC_BITS:0]     sustain_level,
	output logic                        invert_output
);

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [W-1:0] attack_q;
	logic [W-1:0] decay_q;
	logic [W-1:0] release_q;
	logic [W-1:0] sustain_q;
	logic         invert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ONE;
			decay_q   <= ONE;
			release_q <= ONE;
			sustain_q <= ONE;
			invert_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ATTACK_COEFF:  attack_q  <= cfg_wdata;
				REG_DECAY_COEFF:   decay_q   <= cfg_wdata;
				REG_RELEASE_COEFF: release_q <= cfg_wdata;
				REG_SUSTAIN_LEVEL: sustain_q <= cfg_wdata;
				REG_INVERT_OUTPUT: invert_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign attack_coeff  = attack_q;
	assign decay_coeff   = decay_q;
	assign release_coeff = release_q;
	assign sustain_level = sustain_q;
	assign invert_output = invert_q;

endmodule

`default_nettype wire

/* sv/adsr_step.sv */
// Next-state logic of the envelope: flag handling, one shared rounded
// multiply, and the per-phase update. Depends on adsr_pkg for phase codes.
`default_nettype none

module adsr_step
	import adsr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic [PHASE_W-1:0] phase_cur,
	input  wire logic [FRAC_BITS:0] level_cur,
	input  wire logic               note_on,
	input  wire logic               note_off,
	input  wire logic [FRAC_BITS:0] attack_coeff,
	input  wire logic [FRAC_BITS:0] decay_coeff,
	input  wire logic [FRAC_BITS:0] release_coeff,
	input  wire logic [FRAC_BITS:0] sustain_level,
	input  wire logic               invert_output,
	output logic      [PHASE_W-1:0] phase_nxt,
	output logic      [FRAC_BITS:0] level_nxt,
	output logic      [FRAC_BITS:0] level_view
);

	localparam int W  = FRAC_BITS + 1;
	localparam int DW = W + 1;
	localparam int MW = 2 * W + 1;
	localparam int PW = MW + 1;
	localparam int unsigned ONE_INT  = 32'd1 << FRAC_BITS;
	localparam int unsigned ATK_INT  = (11 * ONE_INT + 5) / 10;
	localparam int unsigned SNAP_RAW = (ONE_INT + 500) / 1000;
	localparam int unsigned SNAP_INT = (SNAP_RAW == 0) ? 1 : SNAP_RAW;
	localparam logic [W-1:0]  ONE   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DW-1:0] ATK_T = DW'(ATK_INT);
	localparam logic [DW-1:0] SNAP  = DW'(SNAP_INT);
	localparam logic [PW-1:0] HALF  = PW'(64'd1 << (FRAC_BITS - 1));

	logic [PHASE_W-1:0] ph_on;
	logic [PHASE_W-1:0] ph_eff;
	logic [W-1:0]       sus;
	logic               above;
	logic [W-1:0]       coeff_sel;
	logic [DW-1:0]      diff_sel;
	logic [MW-1:0]      prod;
	logic [PW-1:0]      rnd;
	logic [DW-1:0]      inc;
	logic [DW-1:0]      lvl_x;
	logic [DW-1:0]      sus_x;
	logic [DW-1:0]      up_sum;
	logic [DW-1:0]      dn_dif;
	logic [DW-1:0]      dec_lvl;
	logic [DW-1:0]      dec_dist;

	function automatic logic [W-1:0] sat_fs(input logic [W-1:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

	// Flags: note_on first, then note_off unless idle.
	assign ph_on  = note_on ? PH_ATTACK : phase_cur;
	assign ph_eff = (note_off && (ph_on != PH_IDLE)) ? PH_RELEASE : ph_on;

	assign sus   = sat_fs(sustain_level);
	assign above = level_cur > sus;
	assign lvl_x = DW'(level_cur);
	assign sus_x = DW'(sus);

	// Pick the operands of the single multiplier by phase.
	always_comb begin
		coeff_sel = '0;
		diff_sel  = '0;
		unique case (ph_eff)
			PH_ATTACK: begin
				coeff_sel = sat_fs(attack_coeff);
				diff_sel  = ATK_T - lvl_x;
			end
			PH_DECAY: begin
				coeff_sel = sat_fs(decay_coeff);
				diff_sel  = above ? (lvl_x - sus_x) : (sus_x - lvl_x);
			end
			PH_RELEASE: begin
				coeff_sel = sat_fs(release_coeff);
				diff_sel  = lvl_x;
			end
			default: ;
		endcase
	end

	assign prod = MW'(coeff_sel) * MW'(diff_sel);
	assign rnd  = PW'(prod) + HALF;
	assign inc  = rnd[FRAC_BITS +: DW];

	assign up_sum   = lvl_x + inc;
	assign dn_dif   = lvl_x - inc;
	assign dec_lvl  = above ? dn_dif : up_sum;
	assign dec_dist = (dec_lvl > sus_x) ? (dec_lvl - sus_x) : (sus_x - dec_lvl);

	always_comb begin
		phase_nxt = PH_IDLE;
		level_nxt = '0;
		unique case (ph_eff)
			PH_ATTACK: begin
				if (up_sum >= DW'(ONE)) begin
					phase_nxt = PH_DECAY;
					level_nxt = ONE;
				end else begin
					phase_nxt = PH_ATTACK;
					level_nxt = up_sum[W-1:0];
				end
			end
			PH_DECAY: begin
				if (dec_dist < SNAP) begin
					phase_nxt = PH_SUSTAIN;
					level_nxt = sus;
				end else begin
					phase_nxt = PH_DECAY;
					level_nxt = dec_lvl[W-1:0];
				end
			end
			PH_SUSTAIN: begin
				phase_nxt = PH_SUSTAIN;
				level_nxt = sus;
			end
			PH_RELEASE: begin
				if (dn_dif < SNAP) begin
					phase_nxt = PH_IDLE;
					level_nxt = '0;
				end else begin
					phase_nxt = PH_RELEASE;
					level_nxt = dn_dif[W-1:0];
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
				level_nxt = '0;
			end
		endcase
	end

	assign level_view = invert_output ? (ONE - level_nxt) : level_nxt;

endmodule

`default_nettype wire

/* sv/adsr_envelope_generator_core.sv */
// Exponential ADSR envelope generator, one transaction per audio sample.
// Each accepted input passes through the input register, then the result register
// loaded with the new envelope.
// Throughput: 1 transaction per cycle while out_stall does not hold the result
// register; the combinational multiply and update feed the phase and level registers.
// Reset (arst_n low, asynchronous): phase idle, level 0, both stages empty.
`default_nettype none

`include "adsr_envelope_generator_core_assert.svh"

module adsr_envelope_generator_core
	import adsr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [FRAC_BITS:0]    cfg_wdata,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  note_on,
	input  wire logic                  note_off,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [FRAC_BITS:0]    level_out,
	output logic      [PHASE_W-1:0]    phase_out
);

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// configuration
	logic [W-1:0] attack_coeff;
	logic [W-1:0] decay_coeff;
	logic [W-1:0] release_coeff;
	logic [W-1:0] sustain_level;
	logic         invert_output;

	// input register
	logic valid_s1;
	logic note_on_s1;
	logic note_off_s1;

	// envelope state
	logic [PHASE_W-1:0] phase_q;
	logic [W-1:0]       level_q;

	// result register
	logic               out_valid_q;
	logic [W-1:0]       level_out_q;
	logic [PHASE_W-1:0] phase_out_q;

	// next-state wires
	logic [PHASE_W-1:0] phase_d;
	logic [W-1:0]       level_d;
	logic [W-1:0]       level_view_d;

	logic advance;
	logic in_take;

	adsr_cfg #(
		.FRAC_BITS (FRAC_BITS)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.attack_coeff  (attack_coeff),
		.decay_coeff   (decay_coeff),
		.release_coeff (release_coeff),
		.sustain_level (sustain_level),
		.invert_output (invert_output)
	);

	// Advance the held transaction when the result register is free or is
	// being emptied this cycle; the input register refills in the same cycle.
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the flags until the transaction moves on.
	always_ff @(posedge clk) begin
		if (in_take) begin
			note_on_s1  <= note_on;
			note_off_s1 <= note_off;
		end
	end

	adsr_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.phase_cur     (phase_q),
		.level_cur     (level_q),
		.note_on       (note_on_s1),
		.note_off      (note_off_s1),
		.attack_coeff  (attack_coeff),
		.decay_coeff   (decay_coeff),
		.release_coeff (release_coeff),
		.sustain_level (sustain_level),
		.invert_output (invert_output),
		.phase_nxt     (phase_d),
		.level_nxt     (level_d),
		.level_view    (level_view_d)
	);

	// Commit the envelope state exactly once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			level_q <= level_d;
		end
	end

	// Result register: load on advance, drop once the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_out_q <= level_view_d;
			phase_out_q <= phase_d;
		end
	end

	assign out_valid = out_valid_q;
	assign level_out = level_out_q;
	assign phase_out = phase_out_q;

	// The envelope never leaves the range zero to full scale.
	`ADSR_ASSERT_NOW(a_level_range, 1'b1, level_q <= ONE)
	// Idle always means a silent envelope.
	`ADSR_ASSERT_NOW(a_idle_silent, phase_q == PH_IDLE, level_q == '0)
	// A committed transaction always leaves a result waiting.
	`ADSR_ASSERT_NEXT(a_advance_result, advance, out_valid_q)

endmodule

`default_nettype wire

/* bench/envelope_checker.sv */
// Envelope checker: watches the configuration port and both channels of the
// envelope generator core, predicts every sample and compares it.
// Depends on adsr_pkg for phase codes and register indexes.
`timescale 1ns / 1ps

module envelope_checker
	import adsr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_BITS:0]   cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 note_on,
	input  logic                 note_off,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [FRAC_BITS:0]   level_out,
	input  logic [PHASE_W-1:0]   phase_out,
	output int                   pending,
	output int                   mismatches
);

	localparam int LW = FRAC_BITS + 2;
	localparam int PW = 2 * FRAC_BITS + 4;
	localparam int ONE_I = 1 << FRAC_BITS;
	localparam int SNAP_I = (ONE_I + 500) / 1000;
	localparam logic [LW-1:0] FULL_SCALE = LW'(ONE_I);
	localparam logic [LW-1:0] ATTACK_TARGET = LW'((11 * ONE_I + 5) / 10);
	localparam logic [LW-1:0] SNAP_LIMIT = LW'(SNAP_I == 0 ? 1 : SNAP_I);
	localparam logic [PW-1:0] HALF_LSB = PW'(ONE_I / 2);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [FRAC_BITS:0] level;
		logic [PHASE_W-1:0] phase;
	} envelope_sample_t;

	logic [FRAC_BITS:0] attack_rate, decay_rate, release_rate, sustain_target;
	logic               invert_en;
	logic [LW-1:0]      env_level;
	logic [PHASE_W-1:0] env_phase;

	envelope_sample_t expected_samples[$];

	function automatic logic [LW-1:0] clamp_fs(input logic [FRAC_BITS:0] v);
		return ({1'b0, v} > FULL_SCALE) ? FULL_SCALE : {1'b0, v};
	endfunction

	// rounded coefficient times distance, halves rounding up
	function automatic logic [LW-1:0] rounded_step(input logic [FRAC_BITS:0] coeff,
			input logic [LW-1:0] gap);
		logic [PW-1:0] prod;
		prod = PW'(clamp_fs(coeff)) * PW'(gap) + HALF_LSB;
		return prod[FRAC_BITS +: LW];
	endfunction

	function automatic envelope_sample_t next_sample(input logic on, input logic off);
		logic [LW-1:0] sus;
		logic [LW-1:0] gap;
		logic [LW-1:0] shown;
		envelope_sample_t s;
		sus = clamp_fs(sustain_target);
		if (on)
			env_phase = PH_ATTACK;
		if (off && env_phase != PH_IDLE)
			env_phase = PH_RELEASE;
		case (env_phase)
			PH_ATTACK: begin
				env_level = env_level + rounded_step(attack_rate, ATTACK_TARGET - env_level);
				if (env_level >= FULL_SCALE) begin
					env_level = FULL_SCALE;
					env_phase = PH_DECAY;
				end
			end
			PH_DECAY: begin
				if (env_level > sus)
					env_level = env_level - rounded_step(decay_rate, env_level - sus);
				else
					env_level = env_level + rounded_step(decay_rate, sus - env_level);
				gap = (env_level > sus) ? env_level - sus : sus - env_level;
				if (gap < SNAP_LIMIT) begin
					env_level = sus;
					env_phase = PH_SUSTAIN;
				end
			end
			PH_SUSTAIN: env_level = sus;
			PH_RELEASE: begin
				env_level = env_level - rounded_step(release_rate, env_level);
				if (env_level < SNAP_LIMIT) begin
					env_level = '0;
					env_phase = PH_IDLE;
				end
			end
			default: begin
				env_phase = PH_IDLE;
				env_level = '0;
			end
		endcase
		shown = invert_en ? FULL_SCALE - env_level : env_level;
		s.level = shown[FRAC_BITS:0];
		s.phase = env_phase;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		envelope_sample_t want;
		if (!arst_n) begin
			attack_rate = FULL_SCALE[FRAC_BITS:0];
			decay_rate = FULL_SCALE[FRAC_BITS:0];
			release_rate = FULL_SCALE[FRAC_BITS:0];
			sustain_target = FULL_SCALE[FRAC_BITS:0];
			invert_en = 1'b0;
			env_level = '0;
			env_phase = PH_IDLE;
			expected_samples.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ATTACK_COEFF:  attack_rate = cfg_wdata;
					REG_DECAY_COEFF:   decay_rate = cfg_wdata;
					REG_RELEASE_COEFF: release_rate = cfg_wdata;
					REG_SUSTAIN_LEVEL: sustain_target = cfg_wdata;
					REG_INVERT_OUTPUT: invert_en = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_samples.push_back(next_sample(note_on, note_off));
				pending++;
			end
			if (out_valid && !out_stall) begin
				if (pending == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected sample: level %0d phase %0d",
							$realtime, level_out, phase_out);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					pending--;
					if (want.level !== level_out || want.phase !== phase_out) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: sample mismatch: level exp %0d got %0d, phase exp %0d got %0d",
								$realtime, want.level, level_out, want.phase, phase_out);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

/* bench/tb_top.sv */
// Top of the envelope generator bench: clock, reset, stimulus and verdict.
// Depends on adsr_pkg, adsr_envelope_generator_core and envelope_checker.
`timescale 1ns / 1ps

module tb_top;
	import adsr_pkg::*;

	localparam int FRAC_BITS = 16;
	// no transaction on any port for this long means the core has hung
	localparam int WATCHDOG_LIMIT = 2000;
	// time for results to leave the core's input and result registers, with a margin
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_SAMPLES = 130;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);
	localparam logic [FRAC_BITS:0] UNITY = (FRAC_BITS + 1)'(1 << FRAC_BITS);
	localparam logic [FRAC_BITS:0] ALL_ONES = '1;
	localparam logic [FRAC_BITS:0] ABOVE_UNITY = UNITY + 1'b1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FRAC_BITS:0]   cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 note_on = 1'b0;
	logic                 note_off = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FRAC_BITS:0]   level_out;
	logic [PHASE_W-1:0]   phase_out;

	int pending_samples;
	int mismatch_count;
	int samples_sent = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles = 0;

	adsr_envelope_generator_core #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.note_on(note_on),
		.note_off(note_off),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_out(level_out),
		.phase_out(phase_out)
	);

	envelope_checker #(
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.note_on(note_on),
		.note_off(note_off),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_out(level_out),
		.phase_out(phase_out),
		.pending(pending_samples),
		.mismatches(mismatch_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver side: stall at random, redrawn every cycle on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
	end

	// Count cycles in which no transaction and no register write takes place.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		do @(negedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one sample and hold it until the core takes the transaction.
	// The sender may idle first; valid is only ever lowered on an idle cycle,
	// so a back-to-back transaction never drops and raises valid in one step.
	task automatic push_sample(input logic on, input logic off);
		@(negedge clk);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		note_on <= on;
		note_off <= off;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// Drop valid, then hold the sender until every expected sample is back.
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_samples != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_BITS:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all(input logic [FRAC_BITS:0] atk, input logic [FRAC_BITS:0] dec,
			input logic [FRAC_BITS:0] rel, input logic [FRAC_BITS:0] sus, input logic inv);
		write_reg(REG_ATTACK_COEFF, atk);
		write_reg(REG_DECAY_COEFF, dec);
		write_reg(REG_RELEASE_COEFF, rel);
		write_reg(REG_SUSTAIN_LEVEL, sus);
		write_reg(REG_INVERT_OUTPUT, {{FRAC_BITS{1'b0}}, inv});
	endtask

	// One well-formed note: press, hold, let go, then let the tail ring out.
	task automatic play_note(input int hold, input int tail);
		push_sample(1'b1, 1'b0);
		repeat (hold) push_sample(1'b0, 1'b0);
		push_sample(1'b0, 1'b1);
		repeat (tail) push_sample(1'b0, 1'b0);
	endtask

	// Mostly whole notes with random lengths; the rest is random flag noise,
	// which also covers re-triggers and both flags at once.
	task automatic play_phrase(input int count);
		int start;
		start = samples_sent;
		while (samples_sent - start < count) begin
			if ($urandom_range(9, 0) < 8)
				play_note($urandom_range(0, 40), $urandom_range(0, 40));
			else
				repeat ($urandom_range(8, 1))
					push_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
		end
	endtask

	function automatic logic [FRAC_BITS:0] any_rate(input int lo, input int hi);
		return (FRAC_BITS + 1)'($urandom_range(hi, lo));
	endfunction

	initial begin
		sender_idle_pct = 9;
		receiver_stall_pct = 81;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: every segment completes in a single sample.
		push_sample(1'b0, 1'b1);  // release request while idle: ignored
		push_sample(1'b1, 1'b0);  // attack overshoots, clamps to full scale
		push_sample(1'b0, 1'b0);  // decay snaps onto sustain
		push_sample(1'b0, 1'b0);  // sustain holds
		push_sample(1'b0, 1'b1);  // release drops straight to zero
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b1);  // both flags from idle: attack then release
		drain();

		// Moderate rates with inverted output; the spare index must be ignored.
		write_all(17'd12000, 17'd20000, 17'd25000, 17'd30000, 1'b1);
		write_reg(REG_SPARE, ALL_ONES);
		push_sample(1'b1, 1'b0);
		repeat (3) push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b0);  // re-trigger part way up the attack
		repeat (2) push_sample(1'b0, 1'b0);
		push_sample(1'b0, 1'b1);
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b1);  // both flags while releasing
		push_sample(1'b0, 1'b0);
		drain();

		// Over-range values saturate to full scale; zero decay rate only
		// ends the decay because the snap already holds.
		write_all(ALL_ONES, '0, ABOVE_UNITY, ALL_ONES, 1'b0);
		push_sample(1'b1, 1'b0);
		repeat (2) push_sample(1'b0, 1'b0);
		push_sample(1'b0, 1'b1);
		push_sample(1'b0, 1'b0);
		drain();

		// Slow-ish rates toward a silent sustain, inverted output.
		write_all(any_rate(4000, 40000), any_rate(4000, 40000), any_rate(4000, 40000),
			'0, 1'b1);
		play_phrase(PHASE_SAMPLES);
		drain();

		sender_idle_pct = 81;
		receiver_stall_pct = 9;
		write_all(any_rate(2000, 40000), any_rate(2000, 40000), any_rate(2000, 40000),
			any_rate(0, 1 << FRAC_BITS), 1'b0);
		play_phrase(PHASE_SAMPLES);
		drain();

		// Instant attack, no release at all: only a new note leaves release.
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		write_all(UNITY, any_rate(1000, 20000), '0, any_rate(0, 1 << FRAC_BITS),
			1'($urandom_range(1, 0)));
		play_phrase(PHASE_SAMPLES);
		drain();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
